[sv/mcpa_pkg.sv]
package mcpa_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 4;
  localparam int unsigned MAX_RESULTS      = 4;
  localparam int unsigned RES_CNT_W        = $clog2(MAX_RESULTS);

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SWI_W    = 5;
  localparam int unsigned STATUS_W = 2;

  localparam logic [DATA_W-1:0] TIME_BASE_RESET = 32'd1000000;

  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ENABLE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISABLE    = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BUSY   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BADARG = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_DIV,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/mcpa_if.sv]
interface mcpa_in_if;
  import mcpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAN_W-1:0] channel_index;
  logic [DATA_W-1:0] frequency;
  logic [SWI_W-1:0]  swi_number;

  modport source (output valid, cmd, channel_index, frequency, swi_number, input ready);
  modport sink (input valid, cmd, channel_index, frequency, swi_number, output ready);
endinterface

interface mcpa_out_if;
  import mcpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                fired;
  logic [CHAN_W-1:0]   fired_channel;
  logic [SWI_W-1:0]    fired_swi;
  logic                last;

  modport source (output valid, status, fired, fired_channel, fired_swi, last, input ready);
  modport sink (input valid, status, fired, fired_channel, fired_swi, last, output ready);
endinterface

interface mcpa_cfg_if;
  import mcpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[sv/mcpa_div.sv]
module mcpa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcpa_pkg::div_req_t req_i,
  output mcpa_pkg::div_rsp_t rsp_o
);
  import mcpa_pkg::*;

  localparam int unsigned STEP_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_d = diff[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[sv/multi_channel_periodic_alarm.sv]
// Periodic alarm timer with a 32-bit counter of tick commands and NUM_CHANNELS channels.
// Channels: in_i carries commands (tick, register, unregister, enable, disable), out_o
// returns result items, cfg_i writes the time base rate in hertz (always ready).
// A command gives one result item with last set. A tick gives one firing item per
// matching channel in ascending order, at most four, the final one with last set;
// a tick that matches nothing gives no item.
// A tick is accepted, then the channels are scanned in turn through the single shared
// compare and adder, then the matching ones are emitted. Unregister, enable and disable
// go straight to the response; a register command that passes its checks first runs
// the bit-serial divider and then gives its response.
// in_i is ready only while the sequencer is idle, so one item is in work at a time.
// Results go through a single output register; the next item is accepted while that
// register still holds a result. When the receiver stalls, the sequencer waits with
// its next result until the output register is free.
// Reset clears the tick counter, all periods, alarm times and interrupt numbers,
// disables every channel and loads the time base rate with 1000000.
module multi_channel_periodic_alarm #(
  parameter int unsigned NUM_CHANNELS = mcpa_pkg::NUM_CHANNELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcpa_cfg_if.sink   cfg_i,
  mcpa_in_if.sink    in_i,
  mcpa_out_if.source out_o
);
  import mcpa_pkg::*;

  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  state_e state_q, state_d;

  logic [DATA_W-1:0]       tbr_q;
  logic [DATA_W-1:0]       cnt_q;
  logic [DATA_W-1:0]       period_q [NUM_CHANNELS];
  logic [DATA_W-1:0]       next_q   [NUM_CHANNELS];
  logic [SWI_W-1:0]        irq_q    [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] en_q;
  logic [NUM_CHANNELS-1:0] mask_q, mask_d;
  logic [CW-1:0]           ptr_q;
  logic [RES_CNT_W-1:0]    nres_q;
  logic [CW-1:0]           ch_q;
  logic [SWI_W-1:0]        swi_q;
  logic [STATUS_W-1:0]     st_q, st_d;

  logic                    ov_q;
  logic [STATUS_W-1:0]     o_status_q;
  logic                    o_fired_q;
  logic [CHAN_W-1:0]       o_chan_q;
  logic [SWI_W-1:0]        o_swi_q;
  logic                    o_last_q;

  logic                    acc;
  logic                    ch_ok;
  logic [CW-1:0]           in_ch;
  logic                    freq_bad;
  logic                    busy;
  logic [CW-1:0]           rd_idx;
  logic [DATA_W-1:0]       sum;
  logic                    hit;
  logic                    ptr_end;
  logic                    slot_free;
  logic                    rest;
  logic                    emit_last;
  logic                    emit_load;
  logic                    resp_load;

  logic                    go_tick;
  logic                    go_div;
  logic                    go_resp;
  logic                    do_unreg;
  logic                    do_enable;
  logic                    do_disable;

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign acc         = in_i.valid && in_i.ready;

  assign in_ch    = CW'(in_i.channel_index);
  assign ch_ok    = 32'(in_i.channel_index) < NUM_CHANNELS;
  assign freq_bad = (in_i.frequency == '0) || (in_i.frequency > tbr_q);
  assign busy     = en_q[in_ch];

  // One read address serves both the channel scan and the enable command.
  assign rd_idx  = (state_q == ST_SCAN) ? ptr_q : in_ch;
  assign sum     = ((state_q == ST_SCAN) ? next_q[rd_idx] : cnt_q) + period_q[rd_idx];
  assign hit     = en_q[rd_idx] && (next_q[rd_idx] == cnt_q);
  assign ptr_end = (ptr_q == CW'(NUM_CHANNELS - 1));

  assign slot_free = !ov_q || out_o.ready;

  always_comb begin
    rest = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (32'(i) > 32'(ptr_q)) rest = rest | mask_q[i];
    end
  end

  // The fourth reported firing ends the tick even if more channels matched.
  assign emit_last = (nres_q == RES_CNT_W'(MAX_RESULTS - 1)) || !rest;
  assign emit_load = (state_q == ST_EMIT) && mask_q[ptr_q] && slot_free;
  assign resp_load = (state_q == ST_RESP) && slot_free;

  always_comb begin
    mask_d = mask_q;
    if (state_q == ST_SCAN && hit) mask_d[ptr_q] = 1'b1;
  end

  // Command decode; bad argument checks take precedence over the busy check.
  always_comb begin
    go_tick    = 1'b0;
    go_div     = 1'b0;
    go_resp    = 1'b0;
    do_unreg   = 1'b0;
    do_enable  = 1'b0;
    do_disable = 1'b0;
    st_d       = STATUS_OK;
    if (acc) begin
      case (in_i.cmd)
        CMD_TICK: go_tick = 1'b1;
        CMD_REGISTER: begin
          if (!ch_ok || freq_bad) begin
            st_d    = STATUS_BADARG;
            go_resp = 1'b1;
          end else if (busy) begin
            st_d    = STATUS_BUSY;
            go_resp = 1'b1;
          end else begin
            go_div = 1'b1;
          end
        end
        CMD_UNREGISTER: begin
          go_resp = 1'b1;
          if (!ch_ok) st_d = STATUS_BADARG;
          else if (busy) st_d = STATUS_BUSY;
          else do_unreg = 1'b1;
        end
        CMD_ENABLE: begin
          go_resp = 1'b1;
          if (!ch_ok) st_d = STATUS_BADARG;
          else if (busy) st_d = STATUS_BUSY;
          else do_enable = 1'b1;
        end
        CMD_DISABLE: begin
          go_resp = 1'b1;
          if (!ch_ok) st_d = STATUS_BADARG;
          else do_disable = 1'b1;
        end
        default: begin
          st_d    = STATUS_BADARG;
          go_resp = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (go_tick) state_d = ST_SCAN;
        else if (go_div) state_d = ST_DIV;
        else if (go_resp) state_d = ST_RESP;
      end
      ST_SCAN: begin
        if (ptr_end) state_d = (mask_d == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load && emit_last) state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (div_rsp.done) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign div_req.start    = go_div;
  assign div_req.dividend = tbr_q;
  assign div_req.divisor  = in_i.frequency;

  mcpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tbr_q   <= TIME_BASE_RESET;
      cnt_q   <= '0;
      en_q    <= '0;
      mask_q  <= '0;
      ptr_q   <= '0;
      nres_q  <= '0;
      ov_q    <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        period_q[i] <= '0;
        next_q[i]   <= '0;
        irq_q[i]    <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) tbr_q <= cfg_i.data;

      if (go_tick) begin
        cnt_q  <= cnt_q + DATA_W'(1);
        ptr_q  <= '0;
        mask_q <= '0;
        nres_q <= '0;
      end

      if (do_unreg) begin
        period_q[in_ch] <= '0;
        irq_q[in_ch]    <= '0;
      end
      if (do_enable) begin
        next_q[in_ch] <= sum;
        en_q[in_ch]   <= 1'b1;
      end
      if (do_disable) en_q[in_ch] <= 1'b0;

      if (state_q == ST_DIV && div_rsp.done) begin
        period_q[ch_q] <= div_rsp.quotient;
        irq_q[ch_q]    <= swi_q;
      end

      if (state_q == ST_SCAN) begin
        if (hit) next_q[ptr_q] <= sum;
        mask_q <= mask_d;
        ptr_q  <= ptr_end ? '0 : ptr_q + CW'(1);
      end

      if (state_q == ST_EMIT) begin
        if (emit_load) begin
          nres_q <= nres_q + RES_CNT_W'(1);
          if (!emit_last) ptr_q <= ptr_q + CW'(1);
        end else if (!mask_q[ptr_q]) begin
          ptr_q <= ptr_q + CW'(1);
        end
      end

      if (emit_load || resp_load) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ch_q  <= in_ch;
      swi_q <= in_i.swi_number;
      st_q  <= st_d;
    end else if (state_q == ST_DIV && div_rsp.done) begin
      st_q <= STATUS_OK;
    end

    if (emit_load) begin
      o_status_q <= STATUS_OK;
      o_fired_q  <= 1'b1;
      o_chan_q   <= CHAN_W'(ptr_q);
      o_swi_q    <= irq_q[ptr_q];
      o_last_q   <= emit_last;
    end else if (resp_load) begin
      o_status_q <= st_q;
      o_fired_q  <= 1'b0;
      o_chan_q   <= '0;
      o_swi_q    <= '0;
      o_last_q   <= 1'b1;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.status        = o_status_q;
  assign out_o.fired         = o_fired_q;
  assign out_o.fired_channel = o_chan_q;
  assign out_o.fired_swi     = o_swi_q;
  assign out_o.last          = o_last_q;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mcpa_pkg::*;

  localparam int unsigned CHANNELS = NUM_CHANNELS_DEF;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_DISABLE + 3'd1;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED = '1;

  localparam int unsigned IDLE_PCT = 24;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RUN_LIMIT = 200000;
  localparam int unsigned HOLD_AT_RESULT = 60;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned CALM_SEND_FROM = 200;
  localparam int unsigned CALM_SEND_TO = 280;
  localparam int unsigned CALM_RECV_FROM = 150;
  localparam int unsigned CALM_RECV_TO = 230;
  localparam int unsigned NUM_PHASES = 5;
  localparam int unsigned RANDOM_PER_PHASE = 68;
  localparam int unsigned MAX_PRINTED = 50;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_CONFIG,
    STEP_DRAIN
  } step_kind_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAN_W-1:0] channel_index;
    logic [DATA_W-1:0] frequency;
    logic [SWI_W-1:0]  swi_number;
  } alarm_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                fired;
    logic [CHAN_W-1:0]   fired_channel;
    logic [SWI_W-1:0]    fired_swi;
    logic                last;
  } alarm_result_t;

  typedef struct packed {
    step_kind_e        kind;
    alarm_cmd_t        item;
    logic [DATA_W-1:0] rate;
  } plan_step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mcpa_in_if  in_bus ();
  mcpa_out_if out_bus ();
  mcpa_cfg_if cfg_bus ();

  multi_channel_periodic_alarm DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted copy of the alarm state.
  logic [DATA_W-1:0]   base_rate;
  logic [DATA_W-1:0]   tick_count;
  logic [DATA_W-1:0]   period_len [CHANNELS];
  logic [DATA_W-1:0]   next_fire [CHANNELS];
  logic [SWI_W-1:0]    irq_num [CHANNELS];
  logic [CHANNELS-1:0] armed;

  alarm_result_t awaited_results [$];
  plan_step_t    alarm_plan [$];

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned stall_cycles;
  int unsigned run_cycles;
  logic        plan_done;

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    error_count++;
  endtask

  // Updates the predicted state for one accepted item and queues the results it causes.
  function automatic void predict_alarm_results(input alarm_cmd_t it);
    alarm_result_t       res;
    alarm_result_t       fires [$];
    logic [STATUS_W-1:0] st;
    res = '0;
    if (it.cmd == CMD_TICK) begin
      tick_count = tick_count + 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
        if (armed[i] && next_fire[i] == tick_count) begin
          next_fire[i] = next_fire[i] + period_len[i];
          if (fires.size() < MAX_RESULTS) begin
            res.status = STATUS_OK;
            res.fired = 1'b1;
            res.fired_channel = CHAN_W'(i);
            res.fired_swi = irq_num[i];
            fires.push_back(res);
          end
        end
      end
      foreach (fires[k]) begin
        res = fires[k];
        res.last = (k == fires.size() - 1);
        awaited_results.push_back(res);
      end
    end else begin
      if (it.cmd > CMD_DISABLE || it.channel_index >= CHANNELS) begin
        st = STATUS_BADARG;
      end else if (it.cmd == CMD_DISABLE) begin
        armed[it.channel_index] = 1'b0;
        st = STATUS_OK;
      end else if (it.cmd == CMD_REGISTER && (it.frequency == '0 || it.frequency > base_rate)) begin
        st = STATUS_BADARG;
      end else if (armed[it.channel_index]) begin
        st = STATUS_BUSY;
      end else begin
        st = STATUS_OK;
        case (it.cmd)
          CMD_REGISTER: begin
            period_len[it.channel_index] = base_rate / it.frequency;
            irq_num[it.channel_index] = it.swi_number;
          end
          CMD_UNREGISTER: begin
            period_len[it.channel_index] = '0;
            irq_num[it.channel_index] = '0;
          end
          default: begin
            next_fire[it.channel_index] = tick_count + period_len[it.channel_index];
            armed[it.channel_index] = 1'b1;
          end
        endcase
      end
      res.status = st;
      res.last = 1'b1;
      awaited_results.push_back(res);
    end
  endfunction

  function automatic void queue_command(input logic [CMD_W-1:0] cmd,
                                        input int unsigned ch,
                                        input logic [DATA_W-1:0] freq,
                                        input int unsigned swi);
    plan_step_t step;
    step = '0;
    step.kind = STEP_ITEM;
    step.item = '{cmd, CHAN_W'(ch), freq, SWI_W'(swi)};
    alarm_plan.push_back(step);
  endfunction

  // Mostly frequencies that give short periods, with some bad and some arbitrary ones.
  function automatic logic [DATA_W-1:0] pick_frequency(input logic [DATA_W-1:0] rate);
    int unsigned pick;
    int unsigned div;
    pick = $urandom_range(9);
    div = (rate < 8) ? rate : 8;
    case (pick)
      0: return '0;
      1: return $urandom();
      2: return rate + 1'b1;
      default: return rate / $urandom_range(div, 1);
    endcase
  endfunction

  always @(posedge clk_i) begin : stim_drive
    logic       offer;
    logic       cfg_offer;
    plan_step_t step;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
    end else begin
      offer = in_bus.valid;
      cfg_offer = cfg_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        predict_alarm_results({in_bus.cmd, in_bus.channel_index, in_bus.frequency,
                               in_bus.swi_number});
        items_sent++;
        offer = 1'b0;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        base_rate = cfg_bus.data;
        cfg_offer = 1'b0;
      end
      if (!offer && !cfg_offer && alarm_plan.size() != 0) begin
        step = alarm_plan[0];
        case (step.kind)
          STEP_ITEM: begin
            if ((items_sent >= CALM_SEND_FROM && items_sent < CALM_SEND_TO) ||
                $urandom_range(99) >= IDLE_PCT) begin
              step = alarm_plan.pop_front();
              in_bus.cmd <= step.item.cmd;
              in_bus.channel_index <= step.item.channel_index;
              in_bus.frequency <= step.item.frequency;
              in_bus.swi_number <= step.item.swi_number;
              offer = 1'b1;
            end
          end
          STEP_DRAIN: begin
            if (quiet_cycles > 0) begin
              step = alarm_plan.pop_front();
            end
          end
          default: begin
            // A quiet tick may still be scanning, so the rate waits for a settled block.
            if (quiet_cycles >= SETTLE_CYCLES) begin
              step = alarm_plan.pop_front();
              cfg_bus.data <= step.rate;
              cfg_offer = 1'b1;
            end
          end
        endcase
      end
      plan_done <= !offer && !cfg_offer && alarm_plan.size() == 0;
      in_bus.valid <= offer;
      cfg_bus.valid <= cfg_offer;
    end
  end

  // Sampled on the falling edge so that it sees the settled state of both processes.
  always @(negedge clk_i) begin
    if (!rst_ni || in_bus.valid || awaited_results.size() != 0) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin : result_check
    alarm_result_t got;
    alarm_result_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.status, out_bus.fired, out_bus.fired_channel, out_bus.fired_swi,
               out_bus.last};
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result item arrived with none awaited");
        end else begin
          want = awaited_results.pop_front();
          if (got.status != want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          end
          if (got.fired != want.fired) begin
            report_mismatch($sformatf("fired %0b, expected %0b", got.fired, want.fired));
          end
          if (got.fired_channel != want.fired_channel) begin
            report_mismatch($sformatf("fired_channel %0d, expected %0d",
                                      got.fired_channel, want.fired_channel));
          end
          if (got.fired_swi != want.fired_swi) begin
            report_mismatch($sformatf("fired_swi %0d, expected %0d",
                                      got.fired_swi, want.fired_swi));
          end
          if (got.last != want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
          end
        end
        if (results_seen == HOLD_AT_RESULT) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (results_seen >= CALM_RECV_FROM && results_seen < CALM_RECV_TO) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      run_cycles++;
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT || run_cycles >= RUN_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin : plan_fill
    logic [DATA_W-1:0] phase_rates [NUM_PHASES];
    logic [DATA_W-1:0] rate;
    logic [CMD_W-1:0]  rnd_cmd;
    plan_step_t        step;
    int unsigned       sel;

    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_TICK;
    in_bus.channel_index = '0;
    in_bus.frequency = '0;
    in_bus.swi_number = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    plan_done = 1'b0;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    stall_cycles = 0;
    run_cycles = 0;

    base_rate = TIME_BASE_RESET;
    tick_count = '0;
    armed = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      period_len[i] = '0;
      next_fire[i] = '0;
      irq_num[i] = '0;
    end

    // Directed part, run at the reset time base.
    queue_command(CMD_TICK, '1, '1, '1);
    queue_command(CMD_REGISTER, 0, '0, 3);
    queue_command(CMD_REGISTER, 0, TIME_BASE_RESET + 1, 3);
    queue_command(CMD_REGISTER, 0, '1, 3);
    queue_command(CMD_REGISTER, 0, TIME_BASE_RESET, '1);
    queue_command(CMD_REGISTER, 1, TIME_BASE_RESET / 2, '0);
    queue_command(CMD_REGISTER, 2, 1, 5);
    queue_command(CMD_REGISTER, 3, TIME_BASE_RESET, 17);
    queue_command(CMD_ENABLE, 0, '0, '0);
    queue_command(CMD_ENABLE, 0, '0, '0);
    queue_command(CMD_REGISTER, 0, TIME_BASE_RESET, 9);
    queue_command(CMD_UNREGISTER, 0, '0, '0);
    queue_command(CMD_ENABLE, 1, '0, '0);
    queue_command(CMD_ENABLE, 2, '0, '0);
    queue_command(CMD_ENABLE, 3, '0, '0);
    repeat (3) queue_command(CMD_TICK, '0, '0, '0);
    queue_command(CMD_FIRST_UNUSED, 1, TIME_BASE_RESET, 1);
    queue_command(CMD_LAST_UNUSED, 3, TIME_BASE_RESET, 1);
    queue_command(CMD_DISABLE, 0, '0, '0);
    queue_command(CMD_DISABLE, 0, '0, '0);
    queue_command(CMD_UNREGISTER, 0, '0, '0);
    // A channel armed with no period never matches within this run.
    queue_command(CMD_ENABLE, 0, '0, '0);
    queue_command(CMD_TICK, '0, '0, '0);
    for (int c = 0; c < CHANNELS; c++) begin
      queue_command(CMD_DISABLE, c, '0, '0);
    end

    // Random phases, each at its own time base; a rate of one makes every
    // registered and enabled channel fire on every tick.
    phase_rates = '{32'd1, 32'd8, 32'hFFFF_FFFF, 32'd37, TIME_BASE_RESET};
    for (int p = 0; p < NUM_PHASES; p++) begin
      rate = phase_rates[p];
      step = '0;
      step.kind = STEP_CONFIG;
      step.rate = rate;
      alarm_plan.push_back(step);
      for (int c = 0; c < CHANNELS; c++) begin
        queue_command(CMD_DISABLE, c, '0, '0);
        queue_command(CMD_REGISTER, c, rate / $urandom_range((rate < 4) ? rate : 4, 1),
                      $urandom_range(31));
        queue_command(CMD_ENABLE, c, $urandom(), $urandom_range(31));
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 2 && n == RANDOM_PER_PHASE / 2) begin
          step = '0;
          step.kind = STEP_DRAIN;
          alarm_plan.push_back(step);
        end
        sel = $urandom_range(99);
        if (sel < 58) begin
          rnd_cmd = CMD_TICK;
        end else if (sel < 70) begin
          rnd_cmd = CMD_REGISTER;
        end else if (sel < 78) begin
          rnd_cmd = CMD_UNREGISTER;
        end else if (sel < 88) begin
          rnd_cmd = CMD_ENABLE;
        end else if (sel < 96) begin
          rnd_cmd = CMD_DISABLE;
        end else begin
          rnd_cmd = CMD_FIRST_UNUSED + CMD_W'($urandom_range(2));
        end
        queue_command(rnd_cmd, $urandom_range(3), pick_frequency(rate), $urandom_range(31));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (plan_done);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      report_mismatch($sformatf("%0d result items never arrived", awaited_results.size()));
    end
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mcpa_pkg.sv
sv/mcpa_if.sv
sv/mcpa_div.sv
sv/multi_channel_periodic_alarm.sv
test/testbench.sv
